// File: rtl/fpa_pkg.sv
// Shared types, constants and helpers for the Q24.8 fixed-point ALU.
// No dependencies; used by every module under rtl/.
package fpa_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 8;
  // divider: one quotient bit per stage plus a rounding stage
  localparam int DIV_LAT   = WORD_W + 1;
  // multiplier: product stage, rounding stage, then the delay to line up with the divider
  localparam int MUL_DLY   = DIV_LAT - 2;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t SIGN_W   = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t MAXPOS_W = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [2*WORD_W-1:0] MUL_HALF = (2*WORD_W)'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQ, CMD_NE, CMD_GT, CMD_LT,
    CMD_GE, CMD_LE, CMD_MIN, CMD_MAX, CMD_INC, CMD_DEC, CMD_I2F, CMD_F2I
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // partial remainder, remaining dividend bits, quotient so far, divisor
  typedef struct packed {
    word_t r;
    word_t n;
    word_t q;
    word_t d;
    logic  neg;
    logic  ovf;
  } div_t;

  typedef struct packed {
    cmd_t    cmd;
    word_t   res;
    logic    cmp;
    status_t st;
  } meta_t;

  function automatic word_t encode(input logic neg, input word_t mag);
    return neg ? word_t'(-mag) : mag;
  endfunction

  function automatic word_t sat_val(input logic neg);
    return neg ? SIGN_W : MAXPOS_W;
  endfunction

  function automatic word_t magn(input word_t v);
    return v[WORD_W-1] ? word_t'(-v) : v;
  endfunction

endpackage

// File: rtl/fpa_div_stage.sv
// One restoring-division step: shifts in one dividend bit, yields one quotient bit.
// Depends on fpa_pkg.
module fpa_div_stage (
  input  logic              clk,
  input  logic              en,
  input  fpa_pkg::div_t     d_in,
  output fpa_pkg::div_t     d_out
);

  fpa_pkg::div_t       st_r;
  fpa_pkg::div_t       st_nxt;
  logic [fpa_pkg::WORD_W:0] trial;
  logic                ge;

  always_comb begin
    trial  = {d_in.r, d_in.n[fpa_pkg::WORD_W-1]};
    ge     = trial >= {1'b0, d_in.d};
    st_nxt = d_in;
    st_nxt.r = ge ? fpa_pkg::WORD_W'(trial - {1'b0, d_in.d})
                  : fpa_pkg::WORD_W'(trial);
    st_nxt.n = {d_in.n[fpa_pkg::WORD_W-2:0], 1'b0};
    st_nxt.q = {d_in.q[fpa_pkg::WORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign d_out = st_r;

endmodule

// File: rtl/fpa_divider.sv
// Pipelined fixed-point divider on magnitudes, round half away from zero, saturating.
// Depends on fpa_pkg and fpa_div_stage.
module fpa_divider (
  input  logic           clk,
  input  logic           en,
  input  fpa_pkg::word_t x,
  input  fpa_pkg::word_t d,
  input  logic           neg,
  output fpa_pkg::word_t res,
  output logic           ovf
);

  fpa_pkg::div_t chain [fpa_pkg::WORD_W+1];
  fpa_pkg::word_t res_r, res_nxt;
  logic           ovf_r, ovf_nxt;
  fpa_pkg::div_t  fin;
  logic [fpa_pkg::WORD_W:0] twor;
  logic [fpa_pkg::WORD_W:0] q1;
  logic [fpa_pkg::WORD_W:0] lim;
  logic           up;
  logic           sat;

  // quotient >= 2^WORD_W exactly when the top dividend bits reach the divisor
  always_comb begin
    chain[0].r   = x >> (fpa_pkg::WORD_W - fpa_pkg::FRAC_BITS);
    chain[0].n   = x << fpa_pkg::FRAC_BITS;
    chain[0].q   = '0;
    chain[0].d   = d;
    chain[0].neg = neg;
    chain[0].ovf = (x >> (fpa_pkg::WORD_W - fpa_pkg::FRAC_BITS)) >= d;
  end

  for (genvar i = 0; i < fpa_pkg::WORD_W; i++) begin : g_stage
    fpa_div_stage u_stage (
      .clk   (clk),
      .en    (en),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  always_comb begin
    fin     = chain[fpa_pkg::WORD_W];
    twor    = {fin.r, 1'b0};
    up      = twor >= {1'b0, fin.d};
    q1      = {1'b0, fin.q} + {{fpa_pkg::WORD_W{1'b0}}, up};
    lim     = {1'b0, fpa_pkg::sat_val(fin.neg)};
    sat     = fin.ovf || (q1 > lim);
    res_nxt = sat ? fpa_pkg::sat_val(fin.neg)
                  : fpa_pkg::encode(fin.neg, q1[fpa_pkg::WORD_W-1:0]);
    ovf_nxt = sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

// File: rtl/fpa_mul.sv
// Pipelined fixed-point multiplier: product, round and saturate, then alignment delay.
// Depends on fpa_pkg.
module fpa_mul (
  input  logic           clk,
  input  logic           en,
  input  fpa_pkg::word_t x,
  input  fpa_pkg::word_t y,
  input  logic           neg,
  output fpa_pkg::word_t res,
  output logic           ovf
);

  logic [2*fpa_pkg::WORD_W-1:0] p_r;
  logic                         neg_r;
  logic [2*fpa_pkg::WORD_W-1:0] rnd;
  logic [2*fpa_pkg::WORD_W-1:0] sh;
  logic                         sat;
  fpa_pkg::word_t               res_nxt;
  fpa_pkg::word_t               res_r [fpa_pkg::MUL_DLY+1];
  logic                         ovf_r [fpa_pkg::MUL_DLY+1];

  always_comb begin
    rnd     = p_r + fpa_pkg::MUL_HALF;
    sh      = rnd >> fpa_pkg::FRAC_BITS;
    sat     = sh > {{fpa_pkg::WORD_W{1'b0}}, fpa_pkg::sat_val(neg_r)};
    res_nxt = sat ? fpa_pkg::sat_val(neg_r)
                  : fpa_pkg::encode(neg_r, sh[fpa_pkg::WORD_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= x * y;
      neg_r    <= neg;
      res_r[0] <= res_nxt;
      ovf_r[0] <= sat;
      for (int i = 1; i <= fpa_pkg::MUL_DLY; i++) begin
        res_r[i] <= res_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

  assign res = res_r[fpa_pkg::MUL_DLY];
  assign ovf = ovf_r[fpa_pkg::MUL_DLY];

endmodule

// File: rtl/fixed_point_alu_q8.sv
// Signed Q24.8 fixed-point ALU, top level. Depends on fpa_pkg, fpa_mul, fpa_divider.
// Path from request to result: input stage, 32 divider bit stages, divider rounding stage,
// output register; every command takes the same path length.
// Throughput: one request per cycle; the whole pipeline holds while the output stalls.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module fixed_point_alu_q8 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    in_command,
  input  logic signed [fpa_pkg::WORD_W-1:0] in_operand_a,
  input  logic signed [fpa_pkg::WORD_W-1:0] in_operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [fpa_pkg::WORD_W-1:0] out_result,
  output logic                          out_compare_true,
  output logic [1:0]                    out_status
);

  logic           en;
  fpa_pkg::word_t ua, ub, sum, dif, xa, xb, i2f_lim;
  logic           lt, eq_ab, neg_a;
  fpa_pkg::meta_t m_nxt;
  fpa_pkg::meta_t meta_r [fpa_pkg::DIV_LAT+1];
  logic           vld_r  [fpa_pkg::DIV_LAT+1];
  fpa_pkg::word_t x_r, d_r;
  logic           neg_r;
  logic           dz_r [fpa_pkg::DIV_LAT+1];
  fpa_pkg::word_t mul_res, div_res;
  logic           mul_ovf, div_ovf;
  fpa_pkg::meta_t last;
  logic           out_valid_r;
  fpa_pkg::word_t out_res_r, out_res_nxt;
  logic           out_cmp_r;
  fpa_pkg::status_t out_st_r, out_st_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    ua      = in_operand_a;
    ub      = in_operand_b;
    neg_a   = ua[fpa_pkg::WORD_W-1];
    sum     = ua + ub;
    dif     = ua - ub;
    lt      = $signed(ua) < $signed(ub);
    eq_ab   = ua == ub;
    xa      = fpa_pkg::magn(ua);
    xb      = fpa_pkg::magn(ub);
    i2f_lim = fpa_pkg::sat_val(neg_a) >> fpa_pkg::FRAC_BITS;
    m_nxt.cmd = fpa_pkg::cmd_t'(in_command);
    m_nxt.res = '0;
    m_nxt.cmp = 1'b0;
    m_nxt.st  = fpa_pkg::ST_OK;
    unique case (fpa_pkg::cmd_t'(in_command))
      fpa_pkg::CMD_ADD: begin
        m_nxt.res = sum;
        if (ua[fpa_pkg::WORD_W-1] == ub[fpa_pkg::WORD_W-1] &&
            sum[fpa_pkg::WORD_W-1] != neg_a) begin
          m_nxt.res = fpa_pkg::sat_val(neg_a);
          m_nxt.st  = fpa_pkg::ST_OVF;
        end
      end
      fpa_pkg::CMD_SUB: begin
        m_nxt.res = dif;
        if (ua[fpa_pkg::WORD_W-1] != ub[fpa_pkg::WORD_W-1] &&
            dif[fpa_pkg::WORD_W-1] != neg_a) begin
          m_nxt.res = fpa_pkg::sat_val(neg_a);
          m_nxt.st  = fpa_pkg::ST_OVF;
        end
      end
      fpa_pkg::CMD_MUL, fpa_pkg::CMD_DIV: ;
      fpa_pkg::CMD_EQ: m_nxt.cmp = eq_ab;
      fpa_pkg::CMD_NE: m_nxt.cmp = !eq_ab;
      fpa_pkg::CMD_GT: m_nxt.cmp = !lt && !eq_ab;
      fpa_pkg::CMD_LT: m_nxt.cmp = lt;
      fpa_pkg::CMD_GE: m_nxt.cmp = !lt;
      fpa_pkg::CMD_LE: m_nxt.cmp = lt || eq_ab;
      fpa_pkg::CMD_MIN: m_nxt.res = (lt || eq_ab) ? ua : ub;
      fpa_pkg::CMD_MAX: m_nxt.res = !lt ? ua : ub;
      fpa_pkg::CMD_INC: begin
        if (ua == fpa_pkg::MAXPOS_W) begin
          m_nxt.res = fpa_pkg::MAXPOS_W;
          m_nxt.st  = fpa_pkg::ST_OVF;
        end else begin
          m_nxt.res = ua + fpa_pkg::WORD_W'(1);
        end
      end
      fpa_pkg::CMD_DEC: begin
        if (ua == fpa_pkg::SIGN_W) begin
          m_nxt.res = fpa_pkg::SIGN_W;
          m_nxt.st  = fpa_pkg::ST_OVF;
        end else begin
          m_nxt.res = ua - fpa_pkg::WORD_W'(1);
        end
      end
      fpa_pkg::CMD_I2F: begin
        if (xa > i2f_lim) begin
          m_nxt.res = fpa_pkg::sat_val(neg_a);
          m_nxt.st  = fpa_pkg::ST_OVF;
        end else begin
          m_nxt.res = fpa_pkg::encode(neg_a, xa << fpa_pkg::FRAC_BITS);
        end
      end
      fpa_pkg::CMD_F2I: m_nxt.res = fpa_pkg::word_t'($signed(ua) >>> fpa_pkg::FRAC_BITS);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= fpa_pkg::DIV_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= fpa_pkg::DIV_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= m_nxt;
      dz_r[0]   <= ub == '0;
      x_r       <= xa;
      d_r       <= xb;
      neg_r     <= ua[fpa_pkg::WORD_W-1] ^ ub[fpa_pkg::WORD_W-1];
      for (int i = 1; i <= fpa_pkg::DIV_LAT; i++) begin
        meta_r[i] <= meta_r[i-1];
        dz_r[i]   <= dz_r[i-1];
      end
    end
  end

  fpa_mul u_mul (
    .clk (clk),
    .en  (en),
    .x   (x_r),
    .y   (d_r),
    .neg (neg_r),
    .res (mul_res),
    .ovf (mul_ovf)
  );

  fpa_divider u_div (
    .clk (clk),
    .en  (en),
    .x   (x_r),
    .d   (d_r),
    .neg (neg_r),
    .res (div_res),
    .ovf (div_ovf)
  );

  always_comb begin
    last        = meta_r[fpa_pkg::DIV_LAT];
    out_res_nxt = last.res;
    out_st_nxt  = last.st;
    if (last.cmd == fpa_pkg::CMD_MUL) begin
      out_res_nxt = mul_res;
      out_st_nxt  = mul_ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
    end else if (last.cmd == fpa_pkg::CMD_DIV) begin
      if (dz_r[fpa_pkg::DIV_LAT]) begin
        out_res_nxt = '0;
        out_st_nxt  = fpa_pkg::ST_DZ;
      end else begin
        out_res_nxt = div_res;
        out_st_nxt  = div_ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[fpa_pkg::DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= out_res_nxt;
      out_cmp_r <= last.cmp;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_res_r;
  assign out_compare_true = out_cmp_r;
  assign out_status       = out_st_r;

endmodule
